[rtl/plt_pkg.sv]
// ----------------------------------------------------------------------------
// plt_pkg
// Shared constants, codes and types of the port-mapping lease table.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = ADDR_W + 1;

   localparam int OP_W     = 3;
   localparam int INDEX_W  = 7;
   localparam int STATUS_W = 2;
   localparam int ADDR4_W  = 32;
   localparam int PORT_W   = 16;
   localparam int TIME_W   = 32;

   localparam logic [OP_W-1:0] OP_ADD          = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE       = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND_MAPPED  = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND_CLIENT  = 3'd3;
   localparam logic [OP_W-1:0] OP_NEXT_CLIENT  = 3'd4;
   localparam logic [OP_W-1:0] OP_NEXT_EXPIRED = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd3;

   typedef struct packed {
      logic [ADDR4_W-1:0] client;
      logic [PORT_W-1:0]  local_port;
      logic [PORT_W-1:0]  public_port;
      logic [TIME_W-1:0]  expires;
   } plt_entry_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [INDEX_W-1:0] index;
      plt_entry_type      entry;
      logic [TIME_W-1:0]  now;
   } plt_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   found_index;
      plt_entry_type       entry;
      logic [COUNT_W-1:0]  entry_total;
   } plt_result_type;

endpackage

[rtl/plt_if.sv]
// ----------------------------------------------------------------------------
// plt_req_if / plt_rsp_if
// Valid/ready channels for lease requests and lease results.
// ----------------------------------------------------------------------------
interface plt_req_if;
   logic                           valid;
   logic                           ready;
   logic [plt_pkg::OP_W-1:0]       operation;
   logic [plt_pkg::INDEX_W-1:0]    index;
   logic [plt_pkg::ADDR4_W-1:0]    client;
   logic [plt_pkg::PORT_W-1:0]     local_port;
   logic [plt_pkg::PORT_W-1:0]     public_port;
   logic [plt_pkg::TIME_W-1:0]     expires;
   logic [plt_pkg::TIME_W-1:0]     now;

   modport source (output valid, operation, index, client, local_port, public_port,
                   expires, now, input ready);
   modport sink   (input valid, operation, index, client, local_port, public_port,
                   expires, now, output ready);
endinterface

interface plt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [plt_pkg::STATUS_W-1:0]   status;
   logic [plt_pkg::ADDR_W-1:0]     found_index;
   logic [plt_pkg::ADDR4_W-1:0]    found_client;
   logic [plt_pkg::PORT_W-1:0]     found_local_port;
   logic [plt_pkg::PORT_W-1:0]     found_public_port;
   logic [plt_pkg::TIME_W-1:0]     found_expires;
   logic [plt_pkg::COUNT_W-1:0]    entry_total;

   modport source (output valid, status, found_index, found_client, found_local_port,
                   found_public_port, found_expires, entry_total, input ready);
   modport sink   (input valid, status, found_index, found_client, found_local_port,
                   found_public_port, found_expires, entry_total, output ready);
endinterface

[rtl/port_mapping_lease_table_core.sv]
// ----------------------------------------------------------------------------
// port_mapping_lease_table_core
// Ordered table of port-mapping leases with append, compacting remove and
// first-match searches.
// ----------------------------------------------------------------------------
// One request is worked at a time. An add, or a request that fails its index or
// capacity check or has no entries to walk, is answered from the dispatch state.
// A remove or a search walks the lease memory through its single read port, one
// entry a cycle, with the read data registered. The result sits in an output
// register, so the next request is taken while it waits there.
module port_mapping_lease_table_core (
   input  logic      clock,
   input  logic      reset,
   plt_req_if.sink   req_chan,
   plt_rsp_if.source rsp_chan
);
   import plt_pkg::*;

   plt_request_type req;
   plt_result_type  res;
   logic            start;
   logic            idle;
   logic            res_valid;
   logic            res_ready;

   logic            rsp_valid_ff, rsp_valid_in;
   plt_result_type  rsp_data_ff;

   assign req.operation         = req_chan.operation;
   assign req.index             = req_chan.index;
   assign req.entry.client      = req_chan.client;
   assign req.entry.local_port  = req_chan.local_port;
   assign req.entry.public_port = req_chan.public_port;
   assign req.entry.expires     = req_chan.expires;
   assign req.now               = req_chan.now;

   assign req_chan.ready = idle;
   assign start          = req_chan.valid && idle;

   plt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .idle      (idle),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // load the output register when it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_data_ff.status;
   assign rsp_chan.found_index       = rsp_data_ff.found_index;
   assign rsp_chan.found_client      = rsp_data_ff.entry.client;
   assign rsp_chan.found_local_port  = rsp_data_ff.entry.local_port;
   assign rsp_chan.found_public_port = rsp_data_ff.entry.public_port;
   assign rsp_chan.found_expires     = rsp_data_ff.entry.expires;
   assign rsp_chan.entry_total       = rsp_data_ff.entry_total;

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while a previous one is in progress");

   a_total_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.entry_total <= COUNT_W'(TABLE_DEPTH))
      else $error("entry total exceeds table depth");

   a_fail_clears_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STATUS_OK) |->
         (rsp_chan.found_index == '0 && rsp_chan.found_client == '0 &&
          rsp_chan.found_local_port == '0 && rsp_chan.found_public_port == '0 &&
          rsp_chan.found_expires == '0))
      else $error("failed result carries entry data");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_ready) |=> res_valid)
      else $error("engine dropped a result that was not taken");

endmodule

[rtl/plt_engine.sv]
// ----------------------------------------------------------------------------
// plt_engine
// Lease memory and the sequencer that appends, compacts and searches it.
// ----------------------------------------------------------------------------
module plt_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  plt_pkg::plt_request_type req,
   output logic                     idle,
   output logic                     res_valid,
   input  logic                     res_ready,
   output plt_pkg::plt_result_type  res
);
   import plt_pkg::*;

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_DISPATCH = 2'd1;
   localparam logic [1:0] S_WALK     = 2'd2;
   localparam logic [1:0] S_DONE     = 2'd3;

   plt_entry_type mem [TABLE_DEPTH];

   logic [1:0]         state_ff, state_in;
   plt_request_type    req_ff, req_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]  rd_idx_ff;
   plt_entry_type      rd_data_ff;
   plt_result_type     res_ff, res_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   plt_entry_type      wr_data;
   logic               last;
   logic               hit;

   // Reads walk upward and remove writes one place below the entry just read,
   // so a write never targets an address still in flight on the read side.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_ptr_ff[ADDR_W-1:0]];
      rd_idx_ff  <= rd_ptr_ff[ADDR_W-1:0];
   end

   always_comb begin
      last = ({1'b0, rd_idx_ff} + COUNT_W'(1)) == count_ff;
      case (req_ff.operation)
         OP_FIND_MAPPED:  hit = rd_data_ff.public_port == req_ff.entry.public_port;
         OP_FIND_CLIENT:  hit = rd_data_ff.client == req_ff.entry.client &&
                                rd_data_ff.local_port == req_ff.entry.local_port;
         OP_NEXT_CLIENT:  hit = rd_data_ff.client == req_ff.entry.client;
         OP_NEXT_EXPIRED: hit = rd_data_ff.expires <= req_ff.now;
         default:         hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      rd_vld_in = 1'b0;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = rd_idx_ff - ADDR_W'(1);
      wr_data   = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_in             = '0;
            res_in.entry_total = count_ff;
            state_in           = S_DONE;
            case (req_ff.operation) inside
               OP_ADD: begin
                  if (count_ff >= COUNT_W'(TABLE_DEPTH)) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     wr_addr            = count_ff[ADDR_W-1:0];
                     wr_data            = req_ff.entry;
                     count_in           = count_ff + COUNT_W'(1);
                     res_in.status      = STATUS_OK;
                     res_in.found_index = count_ff[ADDR_W-1:0];
                     res_in.entry       = req_ff.entry;
                     res_in.entry_total = count_ff + COUNT_W'(1);
                  end
               end
               OP_REMOVE: begin
                  if (req_ff.index >= INDEX_W'(count_ff)) begin
                     res_in.status = STATUS_BAD_INDEX;
                  end else begin
                     rd_ptr_in = COUNT_W'(req_ff.index);
                     state_in  = S_WALK;
                  end
               end
               OP_FIND_MAPPED, OP_FIND_CLIENT: begin
                  if (count_ff == '0) begin
                     res_in.status = STATUS_NOT_FOUND;
                  end else begin
                     rd_ptr_in = '0;
                     state_in  = S_WALK;
                  end
               end
               OP_NEXT_CLIENT, OP_NEXT_EXPIRED: begin
                  if (req_ff.index > INDEX_W'(count_ff)) begin
                     res_in.status = STATUS_BAD_INDEX;
                  end else if (req_ff.index == INDEX_W'(count_ff)) begin
                     res_in.status = STATUS_NOT_FOUND;
                  end else begin
                     rd_ptr_in = COUNT_W'(req_ff.index);
                     state_in  = S_WALK;
                  end
               end
               default: begin
                  res_in.status = STATUS_NOT_FOUND;
               end
            endcase
         end
         S_WALK: begin
            // issue one read a cycle; compare the entry that returns
            if (rd_ptr_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_ptr_in = rd_ptr_ff + COUNT_W'(1);
            end
            if (rd_vld_ff) begin
               if (req_ff.operation == OP_REMOVE) begin
                  if (rd_idx_ff == req_ff.index[ADDR_W-1:0]) begin
                     res_in.found_index = rd_idx_ff;
                     res_in.entry       = rd_data_ff;
                  end else begin
                     wr_en = 1'b1;
                  end
                  if (last) begin
                     count_in           = count_ff - COUNT_W'(1);
                     res_in.status      = STATUS_OK;
                     res_in.entry_total = count_ff - COUNT_W'(1);
                     state_in           = S_DONE;
                  end
               end else if (hit) begin
                  res_in.status      = STATUS_OK;
                  res_in.found_index = rd_idx_ff;
                  res_in.entry       = rd_data_ff;
                  state_in           = S_DONE;
               end else if (last) begin
                  res_in.status = STATUS_NOT_FOUND;
                  state_in      = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rd_ptr_ff <= rd_ptr_in;
      res_ff    <= res_in;
   end

   assign idle      = state_ff == S_IDLE;
   assign res_valid = state_ff == S_DONE;
   assign res       = res_ff;

endmodule
